>>> rtl/hashed_timing_wheel_core_assert.svh
// ----------------------------------------------------------------------------
// hashed timing wheel assertion macros
// same-cycle and next-cycle implication checks, disabled while reset is low
// ----------------------------------------------------------------------------
`ifndef HASHED_TIMING_WHEEL_CORE_ASSERT_SVH
`define HASHED_TIMING_WHEEL_CORE_ASSERT_SVH

// consequent holds in the same cycle
`define HTW_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("htw check failed");

// consequent holds in the following cycle
`define HTW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("htw check failed");

`endif

>>> rtl/htw_pkg.sv
// ----------------------------------------------------------------------------
// htw_pkg
// shared constants, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package htw_pkg;

    localparam int TIMER_ENTRIES = 16;
    localparam int ID_W          = 4;
    localparam int WHEEL_SLOTS   = 64;
    localparam int SLOT_W        = 6;
    localparam int CNT_W         = 7;
    localparam int IV_W          = 16;
    localparam int TMO_W         = 20;
    localparam int OP_W          = 2;
    localparam int IN_DATA_W     = 32;
    localparam int OUT_DATA_W    = 8;
    localparam int CFG_IDX_W     = 1;
    localparam int DIV_STEPS     = TMO_W;
    localparam int DIV_CNT_W     = 5;

    localparam logic [OP_W-1:0] OP_START  = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_INTERVAL = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT    = 1'b1;

    localparam logic [IV_W-1:0]  IV_RESET  = 16'd10;
    localparam logic [CNT_W-1:0] CNT_RESET = 7'd64;

    // divider operand / result selection
    localparam logic [1:0] DSEL_TICKS  = 2'd0;
    localparam logic [1:0] DSEL_ROUNDS = 2'd1;
    localparam logic [1:0] DSEL_SLOT   = 2'd2;
    localparam logic [1:0] DSEL_ADV    = 2'd3;

    typedef struct packed {
        logic       load_item;
        logic       write_start;
        logic       remove;
        logic       dec_rounds;
        logic       fire;
        logic       div_go;
        logic       div_cap;
        logic [1:0] div_sel;
        logic       sched_write;
        logic       inc_idx;
        logic       final_push;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            hit;
        logic            has_rounds;
        logic            periodic;
        logic            last_idx;
        logic            pend_valid;
        logic            out_free;
        logic            div_busy;
        logic            div_done;
    } t_status;

endpackage

`default_nettype wire

>>> rtl/hashed_timing_wheel_core.sv
// ----------------------------------------------------------------------------
// hashed_timing_wheel_core
// hashed timing wheel over sixteen timer entries with start, remove and tick
// ----------------------------------------------------------------------------
// one item at a time; every division runs in the shared 20-step divider
// start: three divisions; remove and unused codes: no division
// tick: sixteen entries scanned in turn, then one division
//   plus three divisions for every periodic timer that fires and is rescheduled
// synchronous active-low reset: all timers idle, current slot 0,
//   slot interval 10, slot count 64; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module hashed_timing_wheel_core
    import htw_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // operation[1:0], timer_id[5:2], timeout_ms[25:6], periodic[26]
    input  wire logic [IN_DATA_W-1:0] i_s_tdata,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    // fired[0], fired_id[4:1]
    output logic [OUT_DATA_W-1:0]     o_m_tdata,
    output logic                      o_m_tvalid,
    output logic                      o_m_tlast,
    input  wire logic                 i_m_tready,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [IV_W-1:0]      i_cfg_wdata
);

    t_cmd    w_cmd;
    t_status w_status;

    htw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    htw_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

`default_nettype wire

>>> rtl/htw_div.sv
// ----------------------------------------------------------------------------
// htw_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module htw_div
    import htw_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_go,
    input  wire logic [TMO_W-1:0] i_dividend,
    input  wire logic [IV_W-1:0]  i_divisor,
    output logic                  o_busy,
    output logic                  o_done,
    output logic [TMO_W-1:0]      o_quotient,
    output logic [IV_W-1:0]       o_remainder
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [TMO_W-1:0]     r_quo;
    logic [IV_W-1:0]      r_rem;
    logic [IV_W-1:0]      r_dvs;

    logic [IV_W:0]        w_trial;
    logic [IV_W:0]        w_diff;
    logic                 w_ge;

    assign w_trial = {r_rem, r_quo[TMO_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[TMO_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[IV_W-1:0] : w_trial[IV_W-1:0];
        end
    end

    assign o_busy      = r_busy;
    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

>>> rtl/htw_ctrl.sv
// ----------------------------------------------------------------------------
// htw_ctrl
// sequencer for start, remove and tick items of the timing wheel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "hashed_timing_wheel_core_assert.svh"

module htw_ctrl
    import htw_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_tvalid,
    output logic         o_s_tready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DECODE   = 3'd1;
    localparam logic [2:0] S_DIV_GO   = 3'd2;
    localparam logic [2:0] S_DIV_WAIT = 3'd3;
    localparam logic [2:0] S_WRITE    = 3'd4;
    localparam logic [2:0] S_SCAN     = 3'd5;
    localparam logic [2:0] S_NEXT     = 3'd6;
    localparam logic [2:0] S_FINAL    = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic [1:0] r_dsel;
    logic [1:0] n_dsel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dsel  <= DSEL_TICKS;
        end else begin
            r_state <= n_state;
            r_dsel  <= n_dsel;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_dsel        = r_dsel;
        o_cmd         = '0;
        o_cmd.div_sel = r_dsel;
        o_s_tready    = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_status.op)
                    OP_START: begin
                        o_cmd.write_start = 1'b1;
                        n_dsel            = DSEL_TICKS;
                        n_state           = S_DIV_GO;
                    end
                    OP_REMOVE: begin
                        o_cmd.remove = 1'b1;
                        n_state      = S_FINAL;
                    end
                    OP_TICK: begin
                        n_state = S_SCAN;
                    end
                    default: begin
                        n_state = S_FINAL;
                    end
                endcase
            end
            S_DIV_GO: begin
                o_cmd.div_go = 1'b1;
                n_state      = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.div_cap = 1'b1;
                    case (r_dsel)
                        DSEL_TICKS: begin
                            n_dsel  = DSEL_ROUNDS;
                            n_state = S_DIV_GO;
                        end
                        DSEL_ROUNDS: begin
                            n_dsel  = DSEL_SLOT;
                            n_state = S_DIV_GO;
                        end
                        DSEL_SLOT: begin
                            n_state = S_WRITE;
                        end
                        default: begin
                            n_state = S_FINAL;
                        end
                    endcase
                end
            end
            S_WRITE: begin
                o_cmd.sched_write = 1'b1;
                n_state = (i_status.op == OP_TICK) ? S_NEXT : S_FINAL;
            end
            S_SCAN: begin
                if (!i_status.hit) begin
                    n_state = S_NEXT;
                end else if (i_status.has_rounds) begin
                    o_cmd.dec_rounds = 1'b1;
                    n_state          = S_NEXT;
                end else if (!i_status.pend_valid || i_status.out_free) begin
                    o_cmd.fire = 1'b1;
                    if (i_status.periodic) begin
                        n_dsel  = DSEL_TICKS;
                        n_state = S_DIV_GO;
                    end else begin
                        n_state = S_NEXT;
                    end
                end
            end
            S_NEXT: begin
                if (i_status.last_idx) begin
                    n_dsel  = DSEL_ADV;
                    n_state = S_DIV_GO;
                end else begin
                    o_cmd.inc_idx = 1'b1;
                    n_state       = S_SCAN;
                end
            end
            S_FINAL: begin
                if (i_status.out_free) begin
                    o_cmd.final_push = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `HTW_ASSERT_SAME(a_fire_room, i_clk, i_rst_n, o_cmd.fire && i_status.pend_valid, i_status.out_free)
    `HTW_ASSERT_SAME(a_final_room, i_clk, i_rst_n, o_cmd.final_push, i_status.out_free)
    `HTW_ASSERT_SAME(a_div_idle, i_clk, i_rst_n, o_cmd.div_go, !i_status.div_busy)
    `HTW_ASSERT_NEXT(a_div_start, i_clk, i_rst_n, o_cmd.div_go, i_status.div_busy)

endmodule

`default_nettype wire

>>> rtl/htw_dp.sv
// ----------------------------------------------------------------------------
// htw_dp
// timer table, wheel registers, divider operands and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module htw_dp
    import htw_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic [IN_DATA_W-1:0]  i_s_tdata,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [IV_W-1:0]       i_cfg_wdata,
    input  wire t_cmd                  i_cmd,
    output t_status                    o_status,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0]      o_m_tdata,
    output logic                       o_m_tlast
);

    // configuration
    logic [IV_W-1:0]  r_iv;
    logic [CNT_W-1:0] r_cnt;
    logic [IV_W-1:0]  w_iv_eff;
    logic [CNT_W-1:0] w_n_eff;

    // latched item
    logic [OP_W-1:0]  r_op;
    logic [ID_W-1:0]  r_idx;
    logic [TMO_W-1:0] r_tmo;
    logic             r_per;

    // timer table
    logic [TIMER_ENTRIES-1:0] r_valid;
    logic                     r_periodic [TIMER_ENTRIES];
    logic [SLOT_W-1:0]        r_slot     [TIMER_ENTRIES];
    logic [TMO_W-1:0]         r_rounds   [TIMER_ENTRIES];
    logic [TMO_W-1:0]         r_timeout  [TIMER_ENTRIES];
    logic [SLOT_W-1:0]        r_cur;

    // schedule working registers
    logic [TMO_W-1:0]  r_ticks;
    logic [TMO_W-1:0]  r_new_rounds;
    logic [SLOT_W-1:0] r_mod;
    logic [SLOT_W-1:0] r_new_slot;
    logic [TMO_W-1:0]  w_sched_rounds;

    // pending and output
    logic              r_pend_valid;
    logic [ID_W-1:0]   r_pend_id;
    logic              r_out_valid;
    logic              r_out_fired;
    logic [ID_W-1:0]   r_out_id;
    logic              r_out_last;
    logic              w_out_free;

    // divider
    logic [TMO_W-1:0]  w_dividend;
    logic [IV_W-1:0]   w_divisor;
    logic [CNT_W-1:0]  w_cur_sum;
    logic [CNT_W-1:0]  w_cur_inc;
    logic              w_div_busy;
    logic              w_div_done;
    logic [TMO_W-1:0]  w_quo;
    logic [IV_W-1:0]   w_rem;

    assign w_iv_eff = (r_iv == '0) ? IV_W'(1) : r_iv;

    always_comb begin
        w_n_eff = r_cnt;
        if (r_cnt == '0) begin
            w_n_eff = CNT_W'(1);
        end else if (r_cnt > CNT_W'(WHEEL_SLOTS)) begin
            w_n_eff = CNT_W'(WHEEL_SLOTS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv  <= IV_RESET;
            r_cnt <= CNT_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_SLOT_INTERVAL: r_iv  <= i_cfg_wdata;
                CFG_SLOT_COUNT:    r_cnt <= i_cfg_wdata[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // divider operands
    assign w_cur_sum = {1'b0, r_cur} + {1'b0, r_mod};
    assign w_cur_inc = {1'b0, r_cur} + CNT_W'(1);

    always_comb begin
        w_divisor = IV_W'(w_n_eff);
        case (i_cmd.div_sel)
            DSEL_TICKS: begin
                w_dividend = r_timeout[r_idx];
                w_divisor  = w_iv_eff;
            end
            DSEL_ROUNDS: w_dividend = r_ticks;
            DSEL_SLOT:   w_dividend = TMO_W'(w_cur_sum);
            default:     w_dividend = TMO_W'(w_cur_inc);
        endcase
    end

    htw_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (i_cmd.div_go),
        .i_dividend  (w_dividend),
        .i_divisor   (w_divisor),
        .o_busy      (w_div_busy),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    // capture divider results, item fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op  <= i_s_tdata[1:0];
            r_idx <= (i_s_tdata[1:0] == OP_TICK) ? '0 : i_s_tdata[5:2];
            r_tmo <= i_s_tdata[25:6];
            r_per <= i_s_tdata[26];
        end else if (i_cmd.inc_idx) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.div_cap) begin
            case (i_cmd.div_sel)
                DSEL_TICKS:  r_ticks <= (w_quo == '0) ? TMO_W'(1) : w_quo;
                DSEL_ROUNDS: begin
                    r_new_rounds <= w_quo;
                    r_mod        <= w_rem[SLOT_W-1:0];
                end
                DSEL_SLOT:   r_new_slot <= w_rem[SLOT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= '0;
        end else if (i_cmd.div_cap && i_cmd.div_sel == DSEL_ADV) begin
            r_cur <= w_rem[SLOT_W-1:0];
        end
    end

    // rescheduled timer landing in the current slot loses a round at once
    assign w_sched_rounds = (r_op == OP_TICK && r_new_slot == r_cur && r_new_rounds != '0)
                          ? r_new_rounds - 1'b1 : r_new_rounds;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.remove) begin
            r_valid[r_idx] <= 1'b0;
        end else if (i_cmd.sched_write) begin
            r_valid[r_idx] <= 1'b1;
        end else if (i_cmd.fire && !r_periodic[r_idx]) begin
            r_valid[r_idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_start) begin
            r_timeout[r_idx]  <= r_tmo;
            r_periodic[r_idx] <= r_per;
        end
        if (i_cmd.sched_write) begin
            r_slot[r_idx]   <= r_new_slot;
            r_rounds[r_idx] <= w_sched_rounds;
        end else if (i_cmd.dec_rounds) begin
            r_rounds[r_idx] <= r_rounds[r_idx] - 1'b1;
        end
    end

    // pending result and output register
    assign w_out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.fire && r_pend_valid) begin
                r_out_valid <= 1'b1;
            end else if (i_cmd.final_push) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.fire) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.final_push) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fire) begin
            r_pend_id <= r_idx;
        end
        if (i_cmd.fire && r_pend_valid) begin
            r_out_fired <= 1'b1;
            r_out_id    <= r_pend_id;
            r_out_last  <= 1'b0;
        end else if (i_cmd.final_push) begin
            r_out_fired <= r_pend_valid;
            r_out_id    <= r_pend_valid ? r_pend_id : '0;
            r_out_last  <= 1'b1;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_DATA_W'({r_out_id, r_out_fired});
    assign o_m_tlast  = r_out_last;

    always_comb begin
        o_status            = '0;
        o_status.op         = r_op;
        o_status.hit        = r_valid[r_idx] && (r_slot[r_idx] == r_cur);
        o_status.has_rounds = (r_rounds[r_idx] != '0);
        o_status.periodic   = r_periodic[r_idx];
        o_status.last_idx   = (r_idx == ID_W'(TIMER_ENTRIES - 1));
        o_status.pend_valid = r_pend_valid;
        o_status.out_free   = w_out_free;
        o_status.div_busy   = w_div_busy;
        o_status.div_done   = w_div_done;
    end

endmodule

`default_nettype wire

>>> sim/htw_expiry_checker.sv
// ----------------------------------------------------------------------------
// htw_expiry_checker
// watches the item, result and register ports of the timing wheel, keeps a
// wheel of its own and checks each result against the oldest expected expiry
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module htw_expiry_checker
    import htw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // operation[1:0], timer_id[5:2], timeout_ms[25:6], periodic[26]
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    // fired[0], fired_id[4:1]
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tlast,
    input  logic                  i_m_tready,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [IV_W-1:0]       i_cfg_wdata,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_result_count,
    output int                    o_expiry_count
);

    localparam int ID_LSB  = OP_W;
    localparam int TMO_LSB = OP_W + ID_W;
    localparam int PER_BIT = OP_W + ID_W + TMO_W;

    typedef struct packed {
        logic            fired;
        logic [ID_W-1:0] id;
        logic            last;
    } expiry_t;

    logic              tmr_valid    [TIMER_ENTRIES];
    logic              tmr_periodic [TIMER_ENTRIES];
    logic [SLOT_W-1:0] tmr_slot     [TIMER_ENTRIES];
    logic [TMO_W-1:0]  tmr_rounds   [TIMER_ENTRIES];
    logic [TMO_W-1:0]  tmr_timeout  [TIMER_ENTRIES];
    logic [SLOT_W-1:0] cur_slot;
    logic [IV_W-1:0]   slot_interval;
    logic [CNT_W-1:0]  slot_count;
    expiry_t           expiry_q[$];

    function automatic int unsigned wheel_size();
        if (slot_count == 0) return 1;
        if (slot_count > WHEEL_SLOTS) return WHEEL_SLOTS;
        return slot_count;
    endfunction

    task automatic rearm(input int k);
        int unsigned step;
        int unsigned ticks;
        step  = (slot_interval == 0) ? 1 : slot_interval;
        ticks = (tmr_timeout[k] < step) ? 1 : tmr_timeout[k] / step;
        tmr_rounds[k] = TMO_W'(ticks / wheel_size());
        tmr_slot[k]   = SLOT_W'((cur_slot + ticks) % wheel_size());
    endtask

    task automatic apply_item(input logic [IN_DATA_W-1:0] word);
        logic [OP_W-1:0]   op;
        logic [ID_W-1:0]   id;
        logic [SLOT_W-1:0] here;
        int                fired_ids[$];
        op = word[OP_W-1:0];
        id = word[ID_LSB +: ID_W];
        case (op)
            OP_START: begin
                tmr_timeout[id]  = word[TMO_LSB +: TMO_W];
                tmr_periodic[id] = word[PER_BIT];
                rearm(id);
                tmr_valid[id] = 1'b1;
            end
            OP_REMOVE: begin
                tmr_valid[id] = 1'b0;
            end
            OP_TICK: begin
                here = cur_slot;
                for (int k = 0; k < TIMER_ENTRIES; k++) begin
                    if (tmr_valid[k] && tmr_slot[k] == here) begin
                        if (tmr_rounds[k] != 0) begin
                            tmr_rounds[k] = tmr_rounds[k] - 1'b1;
                        end else begin
                            fired_ids.push_back(k);
                            if (!tmr_periodic[k]) begin
                                tmr_valid[k] = 1'b0;
                            end else begin
                                rearm(k);
                                // rescheduled into the slot being served
                                if (tmr_slot[k] == here && tmr_rounds[k] != 0)
                                    tmr_rounds[k] = tmr_rounds[k] - 1'b1;
                            end
                        end
                    end
                end
                cur_slot = SLOT_W'((cur_slot + 1) % wheel_size());
            end
            default: ;
        endcase
        if (fired_ids.size() == 0) begin
            expiry_q.push_back('{fired: 1'b0, id: '0, last: 1'b1});
        end else begin
            foreach (fired_ids[k])
                expiry_q.push_back('{1'b1, ID_W'(fired_ids[k]), k == fired_ids.size() - 1});
        end
    endtask

    always @(posedge i_clk) begin : watch
        expiry_t want;
        if (!i_rst_n) begin
            slot_interval = IV_RESET;
            slot_count    = CNT_RESET;
            cur_slot      = '0;
            for (int k = 0; k < TIMER_ENTRIES; k++) tmr_valid[k] = 1'b0;
            expiry_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_SLOT_INTERVAL: slot_interval = i_cfg_wdata;
                    CFG_SLOT_COUNT:    slot_count    = i_cfg_wdata[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) apply_item(i_s_tdata);
            if (i_m_tvalid && i_m_tready) begin
                o_result_count++;
                if (i_m_tdata[0]) o_expiry_count++;
                if (expiry_q.size() == 0) begin
                    $error("result with none expected: fired %0b fired_id %0d last %0b",
                           i_m_tdata[0], i_m_tdata[ID_W:1], i_m_tlast);
                    o_fail_count++;
                end else begin
                    want = expiry_q.pop_front();
                    if (i_m_tdata[0] !== want.fired) begin
                        $error("fired: expected %0b, got %0b", want.fired, i_m_tdata[0]);
                        o_fail_count++;
                    end
                    if (i_m_tdata[ID_W:1] !== want.id) begin
                        $error("fired_id: expected %0d, got %0d", want.id, i_m_tdata[ID_W:1]);
                        o_fail_count++;
                    end
                    if (i_m_tlast !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, i_m_tlast);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = expiry_q.size();
    end

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// drives start, remove, tick and unused items into the timing wheel under several
// wheel settings, with random gaps, a long output hold-off and a stretch of
// full rate; the expiry checker beside the block does the comparing
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import htw_pkg::*;

    localparam int                HALF_PERIOD    = 6;
    localparam int                STALL_CYCLES   = 600;
    localparam int                DRAIN_CYCLES   = 150;
    localparam int                WATCHDOG_LIMIT = 6000;
    localparam logic [OP_W-1:0]   OP_UNUSED      = 2'd3;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tvalid;
    logic                  m_tlast;
    logic                  m_tready  = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [IV_W-1:0]       cfg_wdata = '0;

    int          fail_count;
    int          pending;
    int          result_count;
    int          expiry_count;
    int          items_sent   = 0;
    int          quiet_cycles = 0;
    logic        calm         = 1'b0;
    logic        stall_req    = 1'b0;
    int unsigned wheel_iv     = IV_RESET;
    int unsigned wheel_n      = CNT_RESET;

    hashed_timing_wheel_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tdata   (s_tdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tvalid  (m_tvalid),
        .o_m_tlast   (m_tlast),
        .i_m_tready  (m_tready),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    htw_expiry_checker checker_i (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_tdata      (s_tdata),
        .i_s_tvalid     (s_tvalid),
        .i_s_tready     (s_tready),
        .i_m_tdata      (m_tdata),
        .i_m_tvalid     (m_tvalid),
        .i_m_tlast      (m_tlast),
        .i_m_tready     (m_tready),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_index    (cfg_index),
        .i_cfg_wdata    (cfg_wdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count),
        .o_expiry_count (expiry_count)
    );

    initial begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    // receiver: random back-pressure, or one long hold-off on request
    initial begin
        forever begin
            @(posedge clk);
            if (stall_req) begin
                m_tready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
                stall_req = 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(0, 99) >= 21);
            end
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                             input logic [TMO_W-1:0] tmo, input logic per);
        if (!calm && $urandom_range(0, 99) < 21) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 90 : 4)) @(posedge clk);
        end
        s_tdata  <= {{(IN_DATA_W - OP_W - ID_W - TMO_W - 1){1'b0}}, per, tmo, id, op};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        items_sent++;
    endtask

    // wait until every expected result is out and the block has gone quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [IV_W-1:0] val);
        cfg_index <= idx;
        cfg_wdata <= val;
        cfg_wr_en <= 1'b1;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_wheel(input logic [IV_W-1:0] iv, input logic [IV_W-1:0] cnt);
        settle();
        write_reg(CFG_SLOT_INTERVAL, iv);
        write_reg(CFG_SLOT_COUNT, cnt);
        wheel_iv = iv;
        wheel_n  = cnt[CNT_W-1:0];
    endtask

    // mostly timeouts a few turns of the wheel long so that timers do fire
    function automatic logic [TMO_W-1:0] pick_timeout();
        longint unsigned step;
        longint unsigned turns;
        longint unsigned span;
        step  = (wheel_iv == 0) ? 1 : wheel_iv;
        turns = (wheel_n == 0) ? 1 : ((wheel_n > WHEEL_SLOTS) ? WHEEL_SLOTS : wheel_n);
        case ($urandom_range(0, 9))
            0:       span = $urandom() & 32'hFFFFF;
            1:       span = $urandom_range(0, step - 1);
            default: span = $urandom_range(1, 2 * turns + 2) * step
                            + $urandom_range(0, step - 1);
        endcase
        if (span > 20'hFFFFF) span = 20'hFFFFF;
        return TMO_W'(span);
    endfunction

    task automatic random_items(input int total);
        int              done;
        int              pick;
        logic [ID_W-1:0] id;
        logic            per;
        done = 0;
        while (done < total) begin
            pick = $urandom_range(0, 99);
            id   = ID_W'($urandom_range(0, TIMER_ENTRIES - 1));
            per  = 1'($urandom_range(0, 1));
            if (pick < 38)
                send_item(OP_START, id, pick_timeout(), per);
            else if (pick < 52)
                send_item(OP_REMOVE, id, TMO_W'($urandom()), per);
            else if (pick < 96)
                send_item(OP_TICK, id, TMO_W'($urandom()), per);
            else
                send_item(OP_UNUSED, id, TMO_W'($urandom()), per);
            if (pick < 96) done++;
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty wheel, short and maximum timeouts, one-shot and periodic
        send_item(OP_TICK, 0, 0, 0);
        send_item(OP_START, 0, 0, 0);
        send_item(OP_START, 15, 20'hFFFFF, 1);
        send_item(OP_START, 5, 9, 1);
        send_item(OP_START, 10, 20, 1);
        repeat (3) send_item(OP_TICK, 0, 0, 0);
        send_item(OP_REMOVE, 5, 0, 0);
        send_item(OP_REMOVE, 7, 0, 0);
        send_item(OP_UNUSED, 15, 20'hFFFFF, 1);
        send_item(OP_START, 15, 640, 1);

        // zero interval, current slot left beyond a shrunken wheel
        set_wheel(0, 2);
        send_item(OP_TICK, 0, 0, 0);
        send_item(OP_START, 1, 2, 1);
        repeat (6) send_item(OP_TICK, 0, 0, 0);

        set_wheel(1, 8);
        random_items(40);
        set_wheel(16'hFFFF, 16'hFFFF);
        random_items(40);
        set_wheel(7, 12);
        stall_req = 1'b1;
        random_items(40);
        set_wheel(3, 5);
        calm = 1'b1;
        random_items(50);
        calm = 1'b0;
        set_wheel(0, 0);
        random_items(40);
        set_wheel(250, 1);
        random_items(40);
        set_wheel(10, 64);
        random_items(40);
        settle();

        $display("tb_top: %0d items sent over eight wheel settings, %0d results, %0d expiries",
                 items_sent, result_count, expiry_count);
        $display("tb_top: intervals 0 to 65535, slot counts 0 to 127, one long output hold-off");
        if (fail_count == 0 && pending == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/htw_pkg.sv
rtl/htw_div.sv
rtl/htw_ctrl.sv
rtl/htw_dp.sv
rtl/hashed_timing_wheel_core.sv
sim/htw_expiry_checker.sv
sim/tb_top.sv
